// File: hw/rtl/shift_columnar_cipher_assert.svh
// Assertion macros for the shift columnar cipher.
`ifndef SHIFT_COLUMNAR_CIPHER_ASSERT_SVH
`define SHIFT_COLUMNAR_CIPHER_ASSERT_SVH

// Check a consequence in the same cycle as its cause.
`define SCC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check a consequence in the cycle after its cause.
`define SCC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/scc_pkg.sv
// Shared types, constants and byte rotation for the shift columnar cipher.
`default_nettype none

package scc_pkg;

  localparam int MAX_MESSAGE_DEF = 64;
  localparam int BYTE_W = 8;
  localparam int OFS_W = 7;
  localparam int COL_W = 7;

  localparam logic [BYTE_W-1:0] PRINT_LO = 8'd32;
  localparam logic [BYTE_W-1:0] PRINT_HI = 8'd126;
  localparam logic [BYTE_W-1:0] PRINT_SPAN = 8'd95;

  typedef enum logic [1:0] {
    MODE_SHIFT_ENC,
    MODE_SHIFT_DEC,
    MODE_TRANSPOSE,
    MODE_SHIFT_TRANSPOSE
  } mode_t;

  localparam logic [1:0] REG_MODE = 2'd0;
  localparam logic [1:0] REG_OFFSET = 2'd1;
  localparam logic [1:0] REG_COLUMNS = 2'd2;

  typedef struct packed {
    logic store;
    logic drain_start;
    logic shift_load;
    logic drain_load;
    logic clear;
  } scc_cmd_t;

  typedef struct packed {
    logic out_free;
    logic drain_last;
    logic count_zero;
  } scc_status_t;

  function automatic logic [OFS_W-1:0] reduce_offset(input logic [OFS_W-1:0] ofs);
    if (ofs >= PRINT_SPAN[OFS_W-1:0]) begin
      reduce_offset = ofs - PRINT_SPAN[OFS_W-1:0];
    end else begin
      reduce_offset = ofs;
    end
  endfunction

  function automatic logic [BYTE_W-1:0] rotate_byte(input logic [BYTE_W-1:0] b,
                                                   input logic [OFS_W-1:0] k,
                                                   input logic decrypt);
    logic [BYTE_W-1:0] pos;
    logic [BYTE_W-1:0] amt;
    logic [BYTE_W-1:0] sum;
    pos = b - PRINT_LO;
    amt = decrypt ? (PRINT_SPAN - {1'b0, k}) : {1'b0, k};
    sum = pos + amt;
    if (sum >= PRINT_SPAN) begin
      sum = sum - PRINT_SPAN;
    end
    if (b < PRINT_LO || b > PRINT_HI) begin
      rotate_byte = b;
    end else begin
      rotate_byte = sum + PRINT_LO;
    end
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/scc_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none

module scc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: hw/rtl/scc_ctrl.sv
// Controller state machine: input acceptance and column drain sequencing.
`default_nettype none

module scc_ctrl
  import scc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        in_last,
  input  wire mode_t       cipher_mode,
  input  wire scc_status_t status,
  output logic             in_stall,
  output scc_cmd_t         cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EMIT
  } state_t;

  state_t state;
  state_t state_next;
  logic   shift_mode;
  logic   accept;

  assign shift_mode = (cipher_mode == MODE_SHIFT_ENC) || (cipher_mode == MODE_SHIFT_DEC);

  always_comb begin
    state_next = state;
    cmd = '0;
    in_stall = (state != S_IDLE) || (shift_mode && !status.out_free);
    accept = in_valid && !in_stall;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (shift_mode) begin
            cmd.shift_load = 1'b1;
          end else begin
            cmd.store = 1'b1;
            if (in_last) begin
              cmd.drain_start = 1'b1;
              state_next = S_READ;
            end
          end
        end
      end
      S_READ: begin
        if (status.count_zero) begin
          cmd.clear = 1'b1;
          state_next = S_IDLE;
        end else begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.drain_load = 1'b1;
          if (status.drain_last) begin
            cmd.clear = 1'b1;
            state_next = S_IDLE;
          end else begin
            state_next = S_READ;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/scc_dp.sv
// Datapath: byte rotation, message store, drain address walk and output register.
`default_nettype none

module scc_dp
  import scc_pkg::*;
#(
  parameter int MAX_MESSAGE = MAX_MESSAGE_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire scc_cmd_t          cmd,
  input  wire mode_t             cipher_mode,
  input  wire logic [OFS_W-1:0]  shift_offset,
  input  wire logic [COL_W-1:0]  num_cols,
  input  wire logic [BYTE_W-1:0] in_byte,
  input  wire logic              in_last,
  input  wire logic              out_stall,
  output scc_status_t            status,
  output logic                   out_valid,
  output logic      [BYTE_W-1:0] out_byte,
  output logic                   out_last,
  output logic                   overflow
);

  localparam int AW = $clog2(MAX_MESSAGE);
  localparam int CW = $clog2(MAX_MESSAGE + 1);
  localparam int SW = ((CW > COL_W) ? CW : COL_W) + 1;

  logic [CW-1:0]     count;
  logic              dropped;
  logic [AW-1:0]     idx;
  logic [AW-1:0]     col;
  logic [OFS_W-1:0]  k;
  logic [COL_W-1:0]  cols;
  logic [SW-1:0]     next_i;
  logic [SW-1:0]     col_inc;
  logic              step_in_col;
  logic              col_ok;
  logic              full;
  logic              ram_we;
  logic [BYTE_W-1:0] store_byte;
  logic [BYTE_W-1:0] rdata;

  assign k = reduce_offset(shift_offset);
  assign cols = (num_cols == '0) ? COL_W'(1) : num_cols;
  assign next_i = SW'(idx) + SW'(cols);
  assign col_inc = SW'(col) + SW'(1);
  assign step_in_col = next_i < SW'(count);
  assign col_ok = (col_inc < SW'(cols)) && (col_inc < SW'(count));
  assign full = count == CW'(MAX_MESSAGE);
  assign ram_we = cmd.store && !full;
  assign store_byte = (cipher_mode == MODE_SHIFT_TRANSPOSE) ?
                      rotate_byte(in_byte, k, 1'b0) : in_byte;

  assign status.out_free = !out_valid || !out_stall;
  assign status.drain_last = !step_in_col && !col_ok;
  assign status.count_zero = count == '0;

  scc_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MAX_MESSAGE)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count[AW-1:0]),
    .wdata (store_byte),
    .raddr (idx),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      dropped <= 1'b0;
      idx <= '0;
      col <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.store) begin
        if (full) begin
          dropped <= 1'b1;
        end else begin
          count <= count + CW'(1);
        end
      end
      if (cmd.drain_start) begin
        idx <= '0;
        col <= '0;
      end
      if (cmd.drain_load) begin
        if (step_in_col) begin
          idx <= next_i[AW-1:0];
        end else if (col_ok) begin
          idx <= col_inc[AW-1:0];
          col <= col_inc[AW-1:0];
        end
      end
      if (cmd.clear) begin
        count <= '0;
        dropped <= 1'b0;
      end
      if (cmd.shift_load || cmd.drain_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.shift_load) begin
      out_byte <= rotate_byte(in_byte, k, cipher_mode == MODE_SHIFT_DEC);
      out_last <= in_last;
      overflow <= 1'b0;
    end else if (cmd.drain_load) begin
      out_byte <= rdata;
      out_last <= status.drain_last;
      overflow <= status.drain_last && dropped;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/shift_columnar_cipher.sv
// Top level of the shift columnar cipher: register port, controller and datapath.
//
// Input words (in_byte, in_last) and result words (out_byte, out_last,
// overflow) move on valid/stall channels. Registers sit on an APB-style port:
// cipher_mode at 0x0, shift_offset at 0x4, the column count at 0x8.
// Shift modes: one result per word, registered in the cycle after acceptance, one word
// per cycle while the receiver takes results.
// Transposition modes: each word is stored with no result.
// The word with in_last set starts the drain; each result is paced by the
// registered read of the message RAM followed by the output register load.
// Input is stalled for the whole drain. Words beyond MAX_MESSAGE are dropped
// and flagged by overflow on the final result.
// A stalled result holds in the output register, and the drain waits.
// Reset: mode 0, offset 3, one column, empty store; no clearing pass.
`default_nettype none
`include "shift_columnar_cipher_assert.svh"

module shift_columnar_cipher
  import scc_pkg::*;
#(
  parameter int MAX_MESSAGE = MAX_MESSAGE_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [3:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [BYTE_W-1:0] in_byte,
  input  wire logic              in_last,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic      [BYTE_W-1:0] out_byte,
  output logic                   out_last,
  output logic                   overflow
);

  mode_t            cipher_mode;
  logic [OFS_W-1:0] shift_offset;
  logic [COL_W-1:0] num_cols;
  logic             reg_write;
  scc_cmd_t         cmd;
  scc_status_t      status;
  logic             shift_acc;
  logic             drain_go;

  assign pready = 1'b1;
  assign reg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cipher_mode <= MODE_SHIFT_ENC;
      shift_offset <= OFS_W'(3);
      num_cols <= COL_W'(1);
    end else if (reg_write) begin
      case (paddr[3:2])
        REG_MODE:    cipher_mode <= mode_t'(pwdata[1:0]);
        REG_OFFSET:  shift_offset <= pwdata[OFS_W-1:0];
        REG_COLUMNS: num_cols <= pwdata[COL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_MODE:    prdata = 32'(cipher_mode);
      REG_OFFSET:  prdata = 32'(shift_offset);
      REG_COLUMNS: prdata = 32'(num_cols);
      default:     prdata = '0;
    endcase
  end

  scc_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_last     (in_last),
    .cipher_mode (cipher_mode),
    .status      (status),
    .in_stall    (in_stall),
    .cmd         (cmd)
  );

  scc_dp #(
    .MAX_MESSAGE (MAX_MESSAGE)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .cipher_mode  (cipher_mode),
    .shift_offset (shift_offset),
    .num_cols     (num_cols),
    .in_byte      (in_byte),
    .in_last      (in_last),
    .out_stall    (out_stall),
    .status       (status),
    .out_valid    (out_valid),
    .out_byte     (out_byte),
    .out_last     (out_last),
    .overflow     (overflow)
  );

  assign shift_acc = in_valid && !in_stall &&
                     (cipher_mode == MODE_SHIFT_ENC || cipher_mode == MODE_SHIFT_DEC);
  assign drain_go = in_valid && !in_stall && in_last &&
                    (cipher_mode == MODE_TRANSPOSE || cipher_mode == MODE_SHIFT_TRANSPOSE);

  `SCC_ASSERT_NEXT(a_shift_answer, clk, rst, shift_acc, out_valid, "shift word not answered")
  `SCC_ASSERT_NEXT(a_drain_stall, clk, rst, drain_go, in_stall, "input open during drain")
  `SCC_ASSERT_SAME(a_ovf_final, clk, rst, out_valid && overflow, out_last, "overflow not on final")

endmodule

`default_nettype wire

// File: dv/tb_top.sv
// Self-checking testbench for the shift columnar cipher: register port, word traffic, checks.
`default_nettype none

module tb_top;
  import scc_pkg::*;

  localparam logic [1:0] REG_SPARE = 2'd3;
  localparam int STORE_DEPTH = MAX_MESSAGE_DEF;
  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_WORDS = 125;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       ovf;
  } cipher_word_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    bit         sync;
  } plain_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte = '0;
  logic        in_last = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_byte;
  logic        out_last;
  logic        overflow;

  shift_columnar_cipher u_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .in_byte(in_byte), .in_last(in_last),
    .out_valid(out_valid), .out_stall(out_stall), .out_byte(out_byte),
    .out_last(out_last), .overflow(overflow)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predictor state
  mode_t        cfg_mode = MODE_SHIFT_ENC;
  logic [6:0]   cfg_offset = 7'd3;
  logic [6:0]   cfg_cols = 7'd1;
  logic [7:0]   msg_store [STORE_DEPTH];
  int           stored_n = 0;
  bit           dropped = 1'b0;

  cipher_word_t want_q[$];
  plain_word_t  pend_q[$];
  int           gap_max = 0;
  int           hold_req = 0;
  int           errors = 0;

  function automatic logic [7:0] shift_char(logic [7:0] c, bit back);
    int k;
    int pos;
    k = cfg_offset % 95;
    if (c < 8'd32 || c > 8'd126) return c;
    pos = c - 32;
    pos = back ? (pos + 95 - k) % 95 : (pos + k) % 95;
    return 8'(pos + 32);
  endfunction

  function automatic void encipher_word(logic [7:0] b, logic last);
    int cols;
    int n;
    logic [7:0] c;
    if (cfg_mode == MODE_SHIFT_ENC || cfg_mode == MODE_SHIFT_DEC) begin
      want_q.push_back('{shift_char(b, cfg_mode == MODE_SHIFT_DEC), last, 1'b0});
      return;
    end
    c = (cfg_mode == MODE_SHIFT_TRANSPOSE) ? shift_char(b, 1'b0) : b;
    if (stored_n < STORE_DEPTH) begin
      msg_store[stored_n] = c;
      stored_n++;
    end else begin
      dropped = 1'b1;
    end
    if (!last) return;
    cols = (cfg_cols == 0) ? 1 : cfg_cols;
    n = 0;
    for (int col = 0; col < cols && col < stored_n; col++) begin
      for (int i = col; i < stored_n; i += cols) begin
        n++;
        want_q.push_back('{msg_store[i], n == stored_n, (n == stored_n) && dropped});
      end
    end
    stored_n = 0;
    dropped = 1'b0;
  endfunction

  // Driver
  int   gap_left = 0;
  logic nxt_valid;
  plain_word_t cur;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      nxt_valid = in_valid;
      if (in_valid && !in_stall) begin
        encipher_word(in_byte, in_last);
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pend_q.size() != 0 && !(pend_q[0].sync && want_q.size() != 0)) begin
          cur = pend_q.pop_front();
          in_byte <= cur.data;
          in_last <= cur.last;
          nxt_valid = 1'b1;
          gap_left = $urandom_range(0, gap_max);
        end
      end
      in_valid <= nxt_valid;
    end
  end

  // Monitor
  int stall_left = 0;
  int hold_left = 0;
  int hold_seen = 0;
  cipher_word_t want;

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (want_q.size() == 0) begin
          $display("%0t: unexpected word data=%02h last=%b overflow=%b",
                   $time, out_byte, out_last, overflow);
          errors++;
        end else begin
          want = want_q.pop_front();
          if (out_byte !== want.data) begin
            $display("%0t: out_byte expected %02h actual %02h", $time, want.data, out_byte);
            errors++;
          end
          if (out_last !== want.last) begin
            $display("%0t: out_last expected %b actual %b", $time, want.last, out_last);
            errors++;
          end
          if (overflow !== want.ovf) begin
            $display("%0t: overflow expected %b actual %b", $time, want.ovf, overflow);
            errors++;
          end
        end
        stall_left = $urandom_range(0, gap_max);
      end
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic reg_write(logic [1:0] idx, logic [6:0] val);
    logic [31:0] word;
    word = ($urandom & 32'hFFFF_FF80) | {25'd0, val};
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= word;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_MODE: cfg_mode = mode_t'(word[1:0]);
      REG_OFFSET: cfg_offset = word[6:0];
      REG_COLUMNS: cfg_cols = word[6:0];
      default: ;
    endcase
  endtask

  task automatic settle();
    while (pend_q.size() != 0 || in_valid || want_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic void push_word(logic [7:0] b, logic last, bit sync);
    pend_q.push_back('{b, last, sync});
  endfunction

  function automatic logic [7:0] rand_byte();
    return $urandom_range(0, 1) ? 8'($urandom_range(32, 126)) : 8'($urandom_range(0, 255));
  endfunction

  function automatic void push_msg(int len, bit closed, bit sync);
    for (int i = 0; i < len; i++) push_word(rand_byte(), closed && i == len - 1, sync && i == 0);
  endfunction

  int rnd_total;
  int phase_n;
  int len;
  int msg_n;
  mode_t pick;

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: encrypt, offset 3
    push_word(8'd0, 1'b0, 1'b0);
    push_word(8'd31, 1'b0, 1'b0);
    push_word(8'd32, 1'b0, 1'b0);
    push_word(8'd126, 1'b1, 1'b0);
    push_word(8'd127, 1'b0, 1'b0);
    push_word(8'd255, 1'b1, 1'b0);
    settle();

    reg_write(REG_MODE, MODE_SHIFT_DEC);
    reg_write(REG_OFFSET, 7'd94);
    push_word(8'd32, 1'b0, 1'b0);
    push_word(8'd126, 1'b0, 1'b0);
    push_word(8'd33, 1'b1, 1'b0);
    push_word(8'd128, 1'b0, 1'b0);
    settle();

    reg_write(REG_MODE, MODE_SHIFT_ENC);
    reg_write(REG_OFFSET, 7'd127);
    push_word(8'd126, 1'b0, 1'b0);
    push_word(8'd100, 1'b1, 1'b0);
    settle();

    reg_write(REG_MODE, MODE_TRANSPOSE);
    reg_write(REG_COLUMNS, 7'd3);
    for (int i = 0; i < 7; i++) push_word(8'h41 + 8'(i), i == 6, 1'b0);
    settle();

    reg_write(REG_MODE, MODE_SHIFT_TRANSPOSE);
    reg_write(REG_COLUMNS, 7'd0);
    push_msg(3, 1'b1, 1'b0);
    settle();

    reg_write(REG_COLUMNS, 7'd64);
    push_msg(4, 1'b1, 1'b0);
    settle();

    // mode change in mid-message keeps stored bytes
    reg_write(REG_MODE, MODE_TRANSPOSE);
    reg_write(REG_COLUMNS, 7'd2);
    push_msg(2, 1'b0, 1'b0);
    settle();
    reg_write(REG_MODE, MODE_SHIFT_ENC);
    push_word(8'h7A, 1'b1, 1'b0);
    settle();
    reg_write(REG_SPARE, 7'h7F);
    reg_write(REG_MODE, MODE_TRANSPOSE);
    push_word(8'h5A, 1'b1, 1'b0);
    settle();

    rnd_total = 0;
    phase_n = 0;
    while (rnd_total < RANDOM_WORDS) begin
      if (phase_n == 1) pick = MODE_SHIFT_TRANSPOSE;
      else if (phase_n == 2) pick = MODE_TRANSPOSE;
      else pick = mode_t'($urandom_range(0, 3));
      reg_write(REG_MODE, pick);
      case (phase_n % 5)
        0: reg_write(REG_OFFSET, 7'd94);
        1: reg_write(REG_OFFSET, 7'd0);
        2: reg_write(REG_OFFSET, 7'd127);
        default: reg_write(REG_OFFSET, 7'($urandom_range(0, 127)));
      endcase
      case (phase_n % 4)
        0: reg_write(REG_COLUMNS, 7'd64);
        1: reg_write(REG_COLUMNS, 7'd1);
        2: reg_write(REG_COLUMNS, 7'($urandom_range(0, 127)));
        default: reg_write(REG_COLUMNS, 7'($urandom_range(1, 12)));
      endcase
      gap_max = (phase_n % 3 == 0) ? 0 : 10;
      if (phase_n == 1) hold_req++;

      if (pick == MODE_SHIFT_ENC || pick == MODE_SHIFT_DEC) begin
        len = $urandom_range(6, 16);
        for (int i = 0; i < len; i++)
          push_word(rand_byte(), $urandom_range(0, 3) == 0, phase_n % 4 == 0 && i % 5 == 0);
        rnd_total += len;
      end else begin
        if (phase_n == 1) msg_n = 2;
        else if (phase_n == 2) msg_n = 1;
        else msg_n = $urandom_range(1, 3);
        for (int m = msg_n; m > 0; m--) begin
          if (phase_n == 2) len = 70;
          else if (phase_n == 1) len = 12;
          else len = $urandom_range(1, 16);
          push_msg(len, 1'b1, phase_n % 4 == 0);
          rnd_total += len;
        end
        if ($urandom_range(0, 3) == 0) begin
          len = $urandom_range(1, 5);
          push_msg(len, 1'b0, 1'b0);
          rnd_total += len;
        end
      end
      settle();
      phase_n++;
    end

    settle();
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #1600000;
    $display("simulation failed");
    $finish;
  end

endmodule

`default_nettype wire
